// ===== sv/ptrd_pkg.sv =====
// Package for the point-to-ray distance block: field widths, payload types and sqrt constants.
`default_nettype none
package ptrd_pkg;

  localparam int PosW   = 32;   // Q16.16 positions
  localparam int DirW   = 18;   // Q2.16 direction
  localparam int DiffW  = 33;   // origin - point, exact
  localparam int DotW   = 53;   // sum of three diff*dir products
  localparam int TW     = 37;   // t in Q21.16
  localparam int DtW    = 55;   // dir*t in Q.32
  localparam int RndW   = 39;   // dir*t rounded to Q23.16
  localparam int ProjW  = 40;   // diff - rounded product
  localparam int SqW    = 64;   // one square, Q32.32
  localparam int SumW   = 66;   // sum of three squares with carry room
  localparam int RootW  = 32;
  localparam int RemW   = 36;
  localparam int SqrtStages = 16;  // two result bits per stage
  localparam logic [31:0] PerpMax = 32'hFFFF_FFFF;

  // Payload handed to the square root pipeline.
  typedef struct packed {
    logic [PosW-1:0] along;
    logic            sat;
    logic [SqW-1:0]  sum;
  } ptrd_sq_t;

  // Finished result.
  typedef struct packed {
    logic [PosW-1:0] along;
    logic [PosW-1:0] perp;
  } ptrd_res_t;

endpackage
`default_nettype wire

// ===== sv/ptrd_isqrt.sv =====
// Pipelined integer square root, two result bits per stage, with a stallable valid chain.
`default_nettype none
module ptrd_isqrt
  import ptrd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ptrd_sq_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ptrd_res_t      out_data
);

  logic [SqrtStages-1:0] vld_r;
  logic [SqrtStages-1:0] en;
  logic [RemW-1:0]  rem_r   [SqrtStages];
  logic [RootW-1:0] root_r  [SqrtStages];
  logic [SqW-1:0]   v_r     [SqrtStages];
  logic             sat_r   [SqrtStages];
  logic [PosW-1:0]  along_r [SqrtStages];

  logic [RemW-1:0]  rem_nxt  [SqrtStages];
  logic [RootW-1:0] root_nxt [SqrtStages];
  logic [SqW-1:0]   v_nxt    [SqrtStages];

  // One restoring step: bring down two radicand bits and try the next root bit.
  function automatic logic [RemW+RootW-1:0] sqrt_step(input logic [RemW-1:0] rem,
                                                     input logic [RootW-1:0] root,
                                                     input logic [1:0] bits);
    logic [RemW-1:0] r;
    logic [RemW-1:0] trial;
    logic [RootW-1:0] q;
    r     = {rem[RemW-3:0], bits};
    trial = {2'b00, root, 2'b01};
    if (r >= trial) begin
      r = r - trial;
      q = {root[RootW-2:0], 1'b1};
    end else begin
      q = {root[RootW-2:0], 1'b0};
    end
    return {r, q};
  endfunction

  always_comb begin
    en[SqrtStages-1] = !vld_r[SqrtStages-1] || out_ready;
    for (int k = SqrtStages - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    logic [RemW-1:0]  src_rem;
    logic [RootW-1:0] src_root;
    logic [SqW-1:0]   src_v;
    logic [RemW+RootW-1:0] s0;
    logic [RemW+RootW-1:0] s1;
    for (int k = 0; k < SqrtStages; k++) begin
      if (k == 0) begin
        src_rem  = '0;
        src_root = '0;
        src_v    = in_data.sum;
      end else begin
        src_rem  = rem_r[k-1];
        src_root = root_r[k-1];
        src_v    = v_r[k-1];
      end
      s0 = sqrt_step(src_rem, src_root, src_v[SqW-1:SqW-2]);
      s1 = sqrt_step(s0[RemW+RootW-1:RootW], s0[RootW-1:0], src_v[SqW-3:SqW-4]);
      rem_nxt[k]  = s1[RemW+RootW-1:RootW];
      root_nxt[k] = s1[RootW-1:0];
      v_nxt[k]    = {src_v[SqW-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < SqrtStages; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SqrtStages; k++) begin
      if (k == 0) begin
        if (en[0] && in_valid) begin
          rem_r[0]   <= rem_nxt[0];
          root_r[0]  <= root_nxt[0];
          v_r[0]     <= v_nxt[0];
          sat_r[0]   <= in_data.sat;
          along_r[0] <= in_data.along;
        end
      end else begin
        if (en[k] && vld_r[k-1]) begin
          rem_r[k]   <= rem_nxt[k];
          root_r[k]  <= root_nxt[k];
          v_r[k]     <= v_nxt[k];
          sat_r[k]   <= sat_r[k-1];
          along_r[k] <= along_r[k-1];
        end
      end
    end
  end

  assign out_valid      = vld_r[SqrtStages-1];
  assign out_data.along = along_r[SqrtStages-1];
  assign out_data.perp  = sat_r[SqrtStages-1] ? PerpMax : root_r[SqrtStages-1];

endmodule
`default_nettype wire

// ===== sv/point_to_ray_distance_top.sv =====
// Point-to-ray distance: signed distance along a ray and perpendicular distance to its line.
//
// Usage: each input transaction carries a ray (origin, unit direction) and a query point;
// each one yields exactly one output transaction with the distance along the ray (-t,
// signed Q16.16, saturated) and the perpendicular distance (unsigned Q16.16, saturated).
// The block holds no state between transactions.
// Throughput: one transaction per cycle while out_tready is high. The pipeline has
// seven arithmetic stages (difference, products, dot and round, dir*t, projection,
// squares, sum) followed by a 16-stage square root that resolves two bits per stage.
// The last square root stage is the output register.
// Stalls: when out_tready is low the result holds; each stage keeps loading while it
// or a later stage holds a bubble, so in_tready stays high until the pipeline is full.
// Nothing is dropped or repeated.
// Reset: synchronous, active low; clears all valid bits, so the pipeline comes up empty.
`default_nettype none
module point_to_ray_distance_top
  import ptrd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, point_x, point_y, point_z; 2 pad bits
  input  wire logic [247:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // distance_along, distance_perp
  output logic [63:0]       out_tdata
);

  logic signed [PosW-1:0] origin_x, origin_y, origin_z, point_x, point_y, point_z;
  logic signed [DirW-1:0] dir_x, dir_y, dir_z;

  assign origin_x = in_tdata[31:0];
  assign origin_y = in_tdata[63:32];
  assign origin_z = in_tdata[95:64];
  assign dir_x    = in_tdata[113:96];
  assign dir_y    = in_tdata[131:114];
  assign dir_z    = in_tdata[149:132];
  assign point_x  = in_tdata[181:150];
  assign point_y  = in_tdata[213:182];
  assign point_z  = in_tdata[245:214];

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic sq_ready;

  // Stage 1: differences.
  logic signed [DiffW-1:0] s1_diff_r [3];
  logic signed [DirW-1:0]  s1_dir_r  [3];
  // Stage 2: diff*dir products.
  logic signed [DiffW-1:0] s2_diff_r [3];
  logic signed [DirW-1:0]  s2_dir_r  [3];
  logic signed [DotW-3:0]  s2_prod_r [3];
  // Stage 3: rounded dot product.
  logic signed [DiffW-1:0] s3_diff_r [3];
  logic signed [DirW-1:0]  s3_dir_r  [3];
  logic signed [TW-1:0]    s3_t_r;
  // Stage 4: dir*t and saturated distance along.
  logic signed [DiffW-1:0] s4_diff_r [3];
  logic signed [DtW-1:0]   s4_dt_r   [3];
  logic [PosW-1:0]         s4_along_r;
  // Stage 5: projection magnitudes.
  logic [31:0]             s5_mag_r  [3];
  logic                    s5_sat_r;
  logic [PosW-1:0]         s5_along_r;
  // Stage 6: squares.
  logic [SqW-1:0]          s6_sq_r   [3];
  logic                    s6_sat_r;
  logic [PosW-1:0]         s6_along_r;
  // Stage 7: sum of squares.
  ptrd_sq_t                s7_r;

  logic signed [DiffW-1:0] s1_diff_nxt [3];
  logic signed [DotW-3:0]  s2_prod_nxt [3];
  logic signed [DotW-1:0]  s3_dot;
  logic signed [TW-1:0]    s3_t_nxt;
  logic signed [DtW-1:0]   s4_dt_nxt   [3];
  logic signed [TW:0]      s4_neg;
  logic [PosW-1:0]         s4_along_nxt;
  logic [31:0]             s5_mag_nxt  [3];
  logic                    s5_sat_nxt;
  logic [SqW-1:0]          s6_sq_nxt   [3];
  ptrd_sq_t                s7_nxt;
  ptrd_res_t               res;

  // Each stage loads when it is empty or the stage after it moves on.
  assign en7 = !s7_vld_r || sq_ready;
  assign en6 = !s6_vld_r || en7;
  assign en5 = !s5_vld_r || en6;
  assign en4 = !s4_vld_r || en5;
  assign en3 = !s3_vld_r || en4;
  assign en2 = !s2_vld_r || en3;
  assign en1 = !s1_vld_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r <= in_tvalid;
      if (en2) s2_vld_r <= s1_vld_r;
      if (en3) s3_vld_r <= s2_vld_r;
      if (en4) s4_vld_r <= s3_vld_r;
      if (en5) s5_vld_r <= s4_vld_r;
      if (en6) s6_vld_r <= s5_vld_r;
      if (en7) s7_vld_r <= s6_vld_r;
    end
  end

  always_comb begin
    s1_diff_nxt[0] = DiffW'(origin_x) - DiffW'(point_x);
    s1_diff_nxt[1] = DiffW'(origin_y) - DiffW'(point_y);
    s1_diff_nxt[2] = DiffW'(origin_z) - DiffW'(point_z);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_prod_nxt[i] = s1_diff_r[i] * s1_dir_r[i];
    end
  end

  // Round half up to Q21.16: add half an LSB, then an arithmetic shift.
  always_comb begin
    s3_dot = DotW'(s2_prod_r[0]) + DotW'(s2_prod_r[1]) + DotW'(s2_prod_r[2])
           + DotW'(32768);
    s3_t_nxt = s3_dot[DotW-1:16];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_dt_nxt[i] = s3_dir_r[i] * s3_t_r;
    end
    s4_neg = -(TW+1)'(s3_t_r);
    if (s4_neg[TW:PosW-1] == '0 || s4_neg[TW:PosW-1] == '1) begin
      s4_along_nxt = s4_neg[PosW-1:0];
    end else if (s4_neg[TW]) begin
      s4_along_nxt = 32'h8000_0000;
    end else begin
      s4_along_nxt = 32'h7FFF_FFFF;
    end
  end

  // A component of magnitude 2^32 or more saturates the perpendicular distance.
  always_comb begin
    logic signed [DtW-1:0]   rnd_full;
    logic signed [RndW-1:0]  rnd;
    logic signed [ProjW-1:0] proj;
    logic [ProjW-1:0]        mag;
    s5_sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rnd_full = s4_dt_r[i] + DtW'(32768);
      rnd  = rnd_full[DtW-1:16];
      proj = ProjW'(s4_diff_r[i]) - ProjW'(rnd);
      mag  = proj[ProjW-1] ? ProjW'(-proj) : ProjW'(proj);
      s5_mag_nxt[i] = mag[31:0];
      if (mag[ProjW-1:32] != '0) begin
        s5_sat_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_sq_nxt[i] = SqW'(s5_mag_r[i]) * SqW'(s5_mag_r[i]);
    end
  end

  always_comb begin
    logic [SumW-1:0] total;
    total = SumW'(s6_sq_r[0]) + SumW'(s6_sq_r[1]) + SumW'(s6_sq_r[2]);
    s7_nxt.sum   = total[SqW-1:0];
    s7_nxt.sat   = s6_sat_r || (total[SumW-1:SqW] != '0);
    s7_nxt.along = s6_along_r;
  end

  always_ff @(posedge clk) begin
    if (en1 && in_tvalid) begin
      s1_diff_r <= s1_diff_nxt;
      s1_dir_r[0] <= dir_x;
      s1_dir_r[1] <= dir_y;
      s1_dir_r[2] <= dir_z;
    end
    if (en2 && s1_vld_r) begin
      s2_diff_r <= s1_diff_r;
      s2_dir_r  <= s1_dir_r;
      s2_prod_r <= s2_prod_nxt;
    end
    if (en3 && s2_vld_r) begin
      s3_diff_r <= s2_diff_r;
      s3_dir_r  <= s2_dir_r;
      s3_t_r    <= s3_t_nxt;
    end
    if (en4 && s3_vld_r) begin
      s4_diff_r  <= s3_diff_r;
      s4_dt_r    <= s4_dt_nxt;
      s4_along_r <= s4_along_nxt;
    end
    if (en5 && s4_vld_r) begin
      s5_mag_r   <= s5_mag_nxt;
      s5_sat_r   <= s5_sat_nxt;
      s5_along_r <= s4_along_r;
    end
    if (en6 && s5_vld_r) begin
      s6_sq_r    <= s6_sq_nxt;
      s6_sat_r   <= s5_sat_r;
      s6_along_r <= s5_along_r;
    end
    if (en7 && s6_vld_r) begin
      s7_r <= s7_nxt;
    end
  end

  ptrd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s7_vld_r),
    .in_ready  (sq_ready),
    .in_data   (s7_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {res.perp, res.along};

endmodule
`default_nettype wire

// ===== sv/ptrd_checker.sv =====
// Port-level checker for the point-to-ray distance block, bound to its top level.
`default_nettype none
module ptrd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [247:0] in_tdata,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata
);

  // A stalled result must hold its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed or vanished");

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A receiver that is ready lets the whole pipeline advance.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // An empty output register can never back-pressure the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register is empty");

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata);

endmodule

bind point_to_ray_distance_top ptrd_checker u_ptrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
